@@ rtl/olse_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olse_pkg
// Shared constants and types for the ordered list shift engine: command and
// status codes, default sizes and the control bundle sent to every cell.
// ----------------------------------------------------------------------------
package olse_pkg;

  // Default sizes
  localparam int DEFAULT_DEPTH      = 16;
  localparam int DEFAULT_DATA_WIDTH = 32;

  // Field widths fixed by the transaction format
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 2;

  // Match bits examined per scan cycle (power of two)
  localparam int SCAN_W     = 8;
  localparam int SCAN_SEL_W = $clog2(SCAN_W);

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd4;
  localparam logic [CMD_W-1:0] CMD_ERASE      = 3'd5;
  localparam logic [CMD_W-1:0] CMD_FIND       = 3'd6;
  localparam logic [CMD_W-1:0] CMD_NOP        = 3'd7;

  // Status codes
  localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] STS_RANGE = 2'd3;

  // Per-cycle control broadcast along the cell chain
  typedef struct packed {
    logic ins;  // open a slot at pos, shift later entries up
    logic del;  // close the slot at pos, shift later entries down
  } cell_ctl_t;

endpackage

@@ rtl/ordered_list_shift_engine_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_shift_engine_top
// Fixed-capacity ordered list of signed words with push, pop, insert, erase
// and find commands; one result transaction per command.
// ----------------------------------------------------------------------------
// The list lives in a row of DEPTH cells that all shift in the same cycle,
// so push, pop, insert, erase and the no-op code finish in the cycle they are
// accepted and the next command may follow right behind them. A find compares
// every cell in its accept cycle, then a scanner walks the match bits eight
// slots per cycle, and the next command is taken only after the scan result
// has been loaded into the output register. The result sits in an output
// register, so a command is accepted while the previous result is still
// waiting, unless that result is stalled. Full, empty and out-of-range
// commands leave the list unchanged and report their status.
// ----------------------------------------------------------------------------
module ordered_list_shift_engine_top #(
  parameter int DEPTH      = olse_pkg::DEFAULT_DEPTH,
  parameter int DATA_WIDTH = olse_pkg::DEFAULT_DATA_WIDTH,
  parameter int CNT_W      = $clog2(DEPTH + 1),
  parameter int IDX_W      = $clog2(DEPTH)
) (
  input  logic                          clk,
  input  logic                          rst,
  // command channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [olse_pkg::CMD_W-1:0]    cmd,
  input  logic [CNT_W-1:0]              position,
  input  logic signed [DATA_WIDTH-1:0]  value,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [olse_pkg::STATUS_W-1:0] status,
  output logic                          found,
  output logic [IDX_W-1:0]              found_index,
  output logic [CNT_W-1:0]              count,
  output logic                          is_empty
);
  import olse_pkg::*;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                  state;
  logic                  state_next;
  logic [CNT_W-1:0]      cnt;
  logic [CNT_W-1:0]      cnt_next;

  logic                  in_accept;
  logic                  out_free;
  logic                  list_full;
  logic                  list_empty;
  cell_ctl_t             ctl;
  logic [CNT_W-1:0]      op_pos;
  logic [STATUS_W-1:0]   op_status;
  logic                  op_find;

  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]      cell_match;

  logic                  scan_done;
  logic                  scan_hit;
  logic [IDX_W-1:0]      scan_idx;
  logic                  scan_take;

  assign out_free   = !out_valid || !out_stall;
  assign in_stall   = (state != ST_IDLE) || !out_free;
  assign in_accept  = in_valid && !in_stall;
  assign list_full  = (cnt == FULL_CNT);
  assign list_empty = (cnt == '0);
  assign scan_take  = (state == ST_SCAN) && scan_done && out_free;

  // Decode the command into cell control, target slot and status
  always_comb begin
    ctl       = '0;
    op_pos    = '0;
    op_status = STS_OK;
    op_find   = 1'b0;
    cnt_next  = cnt;
    unique case (cmd) inside
      CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT: begin
        if (cmd == CMD_PUSH_FRONT) begin
          op_pos = '0;
        end else if (cmd == CMD_PUSH_BACK) begin
          op_pos = cnt;
        end else begin
          op_pos = position;
        end
        if (list_full) begin
          op_status = STS_FULL;
        end else if (op_pos > cnt) begin
          op_status = STS_RANGE;
        end else begin
          ctl.ins  = in_accept;
          cnt_next = cnt + 1'b1;
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK, CMD_ERASE: begin
        if (cmd == CMD_POP_FRONT) begin
          op_pos = '0;
        end else if (cmd == CMD_POP_BACK) begin
          op_pos = cnt - 1'b1;
        end else begin
          op_pos = position;
        end
        if (list_empty) begin
          op_status = STS_EMPTY;
        end else if (op_pos >= cnt) begin
          op_status = STS_RANGE;
        end else begin
          ctl.del  = in_accept;
          cnt_next = cnt - 1'b1;
        end
      end
      CMD_FIND: begin
        op_find = 1'b1;
      end
      default: begin
        op_status = STS_OK;
      end
    endcase
  end

  // Cell chain
  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_word;
      logic [DATA_WIDTH-1:0] right_word;
      if (gi == 0) begin : g_first
        assign left_word = value;
      end else begin : g_inner_l
        assign left_word = cell_data[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign right_word = cell_data[gi];
      end else begin : g_inner_r
        assign right_word = cell_data[gi+1];
      end
      olse_cell #(
        .DATA_WIDTH (DATA_WIDTH),
        .CNT_W      (CNT_W),
        .IDX        (gi)
      ) u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .pos        (op_pos),
        .cnt        (cnt),
        .word       (value),
        .left_data  (left_word),
        .right_data (right_word),
        .data       (cell_data[gi]),
        .match      (cell_match[gi])
      );
    end
  endgenerate

  // Lowest-index search
  olse_scan #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .start    (in_accept && op_find),
    .match_in (cell_match),
    .take     (scan_take),
    .done     (scan_done),
    .hit      (scan_hit),
    .hit_idx  (scan_idx)
  );

  // Sequence find commands through the scanner
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept && op_find) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_take) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Hold state and entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (in_accept) begin
        cnt <= cnt_next;
      end
    end
  end

  // Drive the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((in_accept && !op_find) || scan_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && !op_find) begin
      status      <= op_status;
      found       <= 1'b0;
      found_index <= '0;
      count       <= cnt_next;
      is_empty    <= (cnt_next == '0);
    end else if (scan_take) begin
      status      <= STS_OK;
      found       <= scan_hit;
      found_index <= scan_hit ? scan_idx : '0;
      count       <= cnt;
      is_empty    <= list_empty;
    end
  end

endmodule

@@ rtl/olse_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olse_cell
// One list slot. Holds a word, takes its left or right neighbor's word when
// the list shifts, loads the new word at the insert point and compares its
// word against the search key.
// ----------------------------------------------------------------------------
module olse_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int CNT_W      = 5,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  olse_pkg::cell_ctl_t   ctl,
  input  logic [CNT_W-1:0]      pos,
  input  logic [CNT_W-1:0]      cnt,
  input  logic [DATA_WIDTH-1:0] word,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  output logic [DATA_WIDTH-1:0] data,
  output logic                  match
);
  import olse_pkg::*;

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  // Shift or load the slot
  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (MY_IDX > pos) begin
        data <= left_data;
      end else if (MY_IDX == pos) begin
        data <= word;
      end
    end else if (ctl.del) begin
      if (MY_IDX >= pos) begin
        data <= right_data;
      end
    end
  end

  // Compare only live slots
  assign match = (MY_IDX < cnt) && (data == word);

endmodule

@@ rtl/olse_scan.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olse_scan
// Lowest-index search over a captured match vector. Examines one group of
// match bits per cycle and holds the result until the controller takes it.
// ----------------------------------------------------------------------------
module olse_scan #(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DEPTH-1:0] match_in,
  input  logic             take,
  output logic             done,
  output logic             hit,
  output logic [IDX_W-1:0] hit_idx
);
  import olse_pkg::*;

  localparam int NGRP  = (DEPTH + SCAN_W - 1) / SCAN_W;
  localparam int VEC_W = NGRP * SCAN_W;
  localparam int GRP_W = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int FULL_W = GRP_W + SCAN_SEL_W;
  localparam logic [GRP_W-1:0] LAST_GRP = GRP_W'(NGRP - 1);

  logic [VEC_W-1:0]      mvec;
  logic [GRP_W-1:0]      grp;
  logic                  busy;
  logic                  grp_any;
  logic [SCAN_SEL_W-1:0] grp_low;
  logic [FULL_W-1:0]     full_idx;

  // Find the lowest set bit of the current group
  always_comb begin
    grp_any = 1'b0;
    grp_low = '0;
    for (int k = SCAN_W - 1; k >= 0; k--) begin
      if (mvec[k]) begin
        grp_any = 1'b1;
        grp_low = SCAN_SEL_W'(k);
      end
    end
  end

  assign full_idx = {grp, grp_low};

  // Walk the groups, low index first
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      if (grp_any || (grp == LAST_GRP)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else if (take) begin
      done <= 1'b0;
    end
  end

  // Shift the match vector and track the group base
  always_ff @(posedge clk) begin
    if (start) begin
      mvec <= VEC_W'(match_in);
      grp  <= '0;
    end else if (busy) begin
      if (grp_any) begin
        hit     <= 1'b1;
        hit_idx <= IDX_W'(full_idx);
      end else if (grp == LAST_GRP) begin
        hit     <= 1'b0;
        hit_idx <= '0;
      end else begin
        mvec <= mvec >> SCAN_W;
        grp  <= grp + 1'b1;
      end
    end
  end

endmodule
